// ----- rtl/acsm_pkg.sv -----
package acsm_pkg;

  localparam int RAW_W  = 12;
  localparam int CHAN_W = 8;
  localparam int STAT_W = 8;
  localparam int VREF_W = 13;
  localparam int UV_W   = 23;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 40;
  localparam int SQS_W  = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_SEL_CHAN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_UV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_UV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MASK = 3'd5;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'd65535;
  localparam logic [9:0]       UV_PER_MV   = 10'd1000;
  localparam logic [11:0]      FULL_SCALE  = 12'd4095;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [CHAN_W-1:0] sel;
    logic [VREF_W-1:0] vref;
    logic [UV_W-1:0]   over;
    logic [UV_W-1:0]   under;
    logic [STAT_W-1:0] fmask;
    logic [STAT_W-1:0] rmask;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             match;
    logic             fault_hit;
    logic             range_hit;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  over;
    logic [CNT_W-1:0]  under;
    logic [CNT_W-1:0]  fault;
    logic [CNT_W-1:0]  rng;
    logic [UV_W-1:0]   mean;
    logic [UV_W-1:0]   minv;
    logic [UV_W-1:0]   maxv;
    logic [UV_W-1:0]   std;
  } report_t;

endpackage

// ----- rtl/adc_channel_stats_monitor.sv -----
// Per-channel statistics over a run of converter samples.
// Samples enter on the in_ channel; a transaction is taken when in_valid is
// high and in_stall is low. The front end keeps samples of the selected
// channel and the sample marked last, and places them in a two-entry queue;
// other samples are dropped at once. A matching sample passes in the back end
// through its sequence of multiply, reciprocal divide, square and accumulate
// steps; in_stall rises only when the queue is full.
// On the last sample the back end computes the report with one shared
// bit-serial divider for three divisions and a bit-serial square root unit;
// a run without a matching sample skips both and reports zero statistics.
// The report is held in an output register on the out_ channel until a
// transaction completes with out_valid high and out_stall low. While the
// receiver stalls, samples still enter the queue until it fills.
// Registers are written on the cfg_ channel; cfg_ready is always high. The user
// writes them only while the block is idle, which the block does not enforce.
// A synchronous reset restores the register defaults and starts an empty run.
module adc_channel_stats_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acsm_pkg::RAW_W-1:0]      in_raw_code,
  input  logic [acsm_pkg::CHAN_W-1:0]     in_sample_channel,
  input  logic [acsm_pkg::STAT_W-1:0]     in_status_bits,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [acsm_pkg::CHAN_W-1:0]     out_report_channel,
  output logic [acsm_pkg::CNT_W-1:0]      out_match_count,
  output logic [acsm_pkg::CNT_W-1:0]      out_over_count,
  output logic [acsm_pkg::CNT_W-1:0]      out_under_count,
  output logic [acsm_pkg::CNT_W-1:0]      out_fault_count,
  output logic [acsm_pkg::CNT_W-1:0]      out_range_count,
  output logic [acsm_pkg::UV_W-1:0]       out_mean_uv,
  output logic [acsm_pkg::UV_W-1:0]       out_min_uv,
  output logic [acsm_pkg::UV_W-1:0]       out_max_uv,
  output logic [acsm_pkg::UV_W-1:0]       out_stddev_uv,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [acsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import acsm_pkg::*;

  cfg_t     cfg_r;
  q_entry_t entry, head;
  report_t  rep;
  logic     push, pop, q_empty, q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sel   <= 8'd0;
      cfg_r.vref  <= 13'd3300;
      cfg_r.over  <= 23'd3000000;
      cfg_r.under <= 23'd300000;
      cfg_r.fmask <= 8'd1;
      cfg_r.rmask <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEL_CHAN:   cfg_r.sel   <= cfg_data[CHAN_W-1:0];
        CFG_VREF_MV:    cfg_r.vref  <= cfg_data[VREF_W-1:0];
        CFG_OVER_UV:    cfg_r.over  <= cfg_data[UV_W-1:0];
        CFG_UNDER_UV:   cfg_r.under <= cfg_data[UV_W-1:0];
        CFG_FAULT_MASK: cfg_r.fmask <= cfg_data[STAT_W-1:0];
        CFG_RANGE_MASK: cfg_r.rmask <= cfg_data[STAT_W-1:0];
        default: ;
      endcase
    end
  end

  acsm_front u_front (
    .in_valid          (in_valid),
    .in_raw_code       (in_raw_code),
    .in_sample_channel (in_sample_channel),
    .in_status_bits    (in_status_bits),
    .in_last_sample    (in_last_sample),
    .cfg               (cfg_r),
    .q_full            (q_full),
    .in_stall          (in_stall),
    .push              (push),
    .entry             (entry)
  );

  acsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  acsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .rep_valid (out_valid),
    .rep_stall (out_stall),
    .rep       (rep)
  );

  assign out_report_channel = rep.chan;
  assign out_match_count    = rep.cnt;
  assign out_over_count     = rep.over;
  assign out_under_count    = rep.under;
  assign out_fault_count    = rep.fault;
  assign out_range_count    = rep.rng;
  assign out_mean_uv        = rep.mean;
  assign out_min_uv         = rep.minv;
  assign out_max_uv         = rep.maxv;
  assign out_stddev_uv      = rep.std;

  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_uv <= out_mean_uv) && (out_mean_uv <= out_max_uv))
    else $error("Report mean lies outside the min/max range.");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_over_count <= out_match_count) &&
                  (out_under_count <= out_match_count) &&
                  (out_fault_count <= out_match_count) &&
                  (out_range_count <= out_match_count))
    else $error("A report counter exceeds the match count.");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_count == '0) |->
      (out_max_uv == '0) && (out_stddev_uv == '0))
    else $error("A report without matches carries nonzero statistics.");

endmodule

// ----- rtl/acsm_front.sv -----
module acsm_front (
  input  logic                      in_valid,
  input  logic [acsm_pkg::RAW_W-1:0]  in_raw_code,
  input  logic [acsm_pkg::CHAN_W-1:0] in_sample_channel,
  input  logic [acsm_pkg::STAT_W-1:0] in_status_bits,
  input  logic                      in_last_sample,
  input  acsm_pkg::cfg_t            cfg,
  input  logic                      q_full,
  output logic                      in_stall,
  output logic                      push,
  output acsm_pkg::q_entry_t        entry
);
  import acsm_pkg::*;

  always_comb begin
    entry.raw       = in_raw_code;
    entry.match     = (in_sample_channel == cfg.sel);
    entry.fault_hit = |(in_status_bits & cfg.fmask);
    entry.range_hit = |(in_status_bits & cfg.rmask);
    entry.last      = in_last_sample;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && (entry.match || entry.last);

endmodule

// ----- rtl/acsm_queue.sv -----
module acsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  acsm_pkg::q_entry_t push_data,
  input  logic               pop,
  output acsm_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);
  import acsm_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW    = $clog2(QDEPTH + 1);

  q_entry_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/acsm_div.sv -----
module acsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [acsm_pkg::SQS_W-1:0] dividend,
  input  logic [acsm_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [acsm_pkg::SQS_W-1:0] quotient,
  output logic [acsm_pkg::CNT_W-1:0] remainder
);
  import acsm_pkg::*;

  localparam int SW = $clog2(SQS_W + 1);

  logic [SQS_W-1:0] quo_r;
  logic [CNT_W-1:0] rem_r, dvs_r;
  logic [SW-1:0]    cnt_r;
  logic             done_r;
  logic [CNT_W:0]   shl, diff;
  logic             ge;

  assign shl  = {rem_r, quo_r[SQS_W-1]};
  assign ge   = (shl >= {1'b0, dvs_r});
  assign diff = shl - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[SQS_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : shl[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= SW'(SQS_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/acsm_sqrt.sv -----
module acsm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [acsm_pkg::SQS_W-1:0] radicand,
  output logic                       done,
  output logic [acsm_pkg::UV_W-1:0]  root
);
  import acsm_pkg::*;

  localparam int RW = SQS_W / 2;
  localparam int SW = $clog2(RW + 1);

  logic [SQS_W-1:0] rad_r;
  logic [RW+1:0]    rem_r;
  logic [RW-1:0]    root_r;
  logic [SW-1:0]    cnt_r;
  logic             done_r;
  logic [RW+3:0]    rem_t, trial, diff;
  logic             ge;

  assign rem_t = {rem_r, rad_r[SQS_W-1:SQS_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = (rem_t >= trial);
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= {rad_r[SQS_W-3:0], 2'b00};
      rem_r  <= ge ? diff[RW+1:0] : rem_t[RW+1:0];
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= SW'(RW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r[UV_W-1:0];

endmodule

// ----- rtl/acsm_back.sv -----
module acsm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  acsm_pkg::cfg_t     cfg,
  input  acsm_pkg::q_entry_t head,
  input  logic               q_empty,
  output logic               pop,
  output logic               rep_valid,
  input  logic               rep_stall,
  output acsm_pkg::report_t  rep
);
  import acsm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MUL2 = 5'd1;
  localparam logic [4:0] S_EST  = 5'd2;
  localparam logic [4:0] S_FIX  = 5'd3;
  localparam logic [4:0] S_SQ   = 5'd4;
  localparam logic [4:0] S_ACC  = 5'd5;
  localparam logic [4:0] R_CHK  = 5'd6;
  localparam logic [4:0] R_DIV1 = 5'd7;
  localparam logic [4:0] R_WDIV = 5'd8;
  localparam logic [4:0] R_M1   = 5'd9;
  localparam logic [4:0] R_M2   = 5'd10;
  localparam logic [4:0] R_M3   = 5'd11;
  localparam logic [4:0] R_M4   = 5'd12;
  localparam logic [4:0] R_DIV2 = 5'd13;
  localparam logic [4:0] R_SUB1 = 5'd14;
  localparam logic [4:0] R_SUB2 = 5'd15;
  localparam logic [4:0] R_DIV3 = 5'd16;
  localparam logic [4:0] R_SQRT = 5'd17;
  localparam logic [4:0] R_WSQ  = 5'd18;
  localparam logic [4:0] R_OUT  = 5'd19;

  logic [4:0]       state_r, ret_r;
  q_entry_t         ent_r;
  logic [24:0]      prod_r;
  logic [34:0]      x_r;
  logic [23:0]      qe_r;
  logic [UV_W-1:0]  uv_r;
  logic [45:0]      sq_r;
  logic             took_r;

  logic [CNT_W-1:0] tally_r, over_r, under_r, fault_r, rng_r;
  logic [SUM_W-1:0] sum_r;
  logic [SQS_W-1:0] sumsq_r;
  logic [UV_W-1:0]  low_r, high_r;

  logic [SQS_W-1:0] dq_r;
  logic [CNT_W-1:0] drem_r;
  logic [UV_W-1:0]  q_r;
  logic [CNT_W-1:0] r_r;
  logic [61:0]      a_r;
  logic [38:0]      b_r;
  logic [31:0]      c_r;
  logic [SQS_W-1:0] sub_r;
  report_t          rep_r;

  logic [35:0]      est_sum, fix_rem;
  logic [23:0]      qinc;
  logic             take;
  logic [SQS_W-1:0] xdiff, div_in, div_q;
  logic [CNT_W-1:0] div_r;
  logic             div_start, div_done, sq_start, sq_done;
  logic [UV_W-1:0]  sq_root;

  assign est_sum = 36'(x_r) + 36'(x_r >> 12) + 36'(x_r >> 24);
  assign fix_rem = 36'(x_r) - {qe_r, 12'b0} + 36'(qe_r);
  assign qinc    = qe_r + 24'd1;
  assign take    = ent_r.match && (tally_r < MAX_SAMPLES);
  assign xdiff   = (sumsq_r >= sub_r) ? (sumsq_r - sub_r) : '0;

  assign div_start = (state_r == R_DIV1) || (state_r == R_DIV2) || (state_r == R_DIV3);
  assign sq_start  = (state_r == R_SQRT);

  always_comb begin
    case (state_r)
      R_DIV1:  div_in = SQS_W'(sum_r);
      R_DIV2:  div_in = SQS_W'(c_r);
      default: div_in = xdiff;
    endcase
  end

  acsm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_in),
    .divisor   (tally_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  acsm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (dq_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign rep_valid = (state_r == R_OUT);
  assign rep       = rep_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r  <= head;
      prod_r <= 25'(head.raw) * 25'(cfg.vref);
    end
    if (state_r == S_MUL2) begin
      x_r <= 35'(prod_r) * 35'(UV_PER_MV);
    end
    if (state_r == S_EST) begin
      qe_r <= est_sum[35:12];
    end
    if (state_r == S_FIX) begin
      uv_r <= (fix_rem >= 36'(FULL_SCALE)) ? qinc[UV_W-1:0] : qe_r[UV_W-1:0];
    end
    if (state_r == S_SQ) begin
      sq_r <= 46'(uv_r) * 46'(uv_r);
    end
    if (state_r == R_WDIV && div_done) begin
      dq_r   <= div_q;
      drem_r <= div_r;
    end
    if (state_r == R_M1) begin
      q_r <= dq_r[UV_W-1:0];
      r_r <= drem_r;
      a_r <= 62'(46'(dq_r[UV_W-1:0]) * 46'(dq_r[UV_W-1:0]));
    end
    if (state_r == R_M2) begin
      a_r <= 62'(a_r[45:0]) * 62'(tally_r);
    end
    if (state_r == R_M3) begin
      b_r <= 39'(q_r) * 39'(r_r);
    end
    if (state_r == R_M4) begin
      c_r <= 32'(r_r) * 32'(r_r);
    end
    if (state_r == R_SUB1) begin
      sub_r <= SQS_W'(a_r) + SQS_W'({b_r, 1'b0});
    end
    if (state_r == R_SUB2) begin
      sub_r <= sub_r + dq_r + SQS_W'(drem_r != '0);
    end
    if (state_r == R_CHK || (state_r == R_WSQ && sq_done)) begin
      rep_r.chan  <= cfg.sel;
      rep_r.cnt   <= tally_r;
      rep_r.over  <= over_r;
      rep_r.under <= under_r;
      rep_r.fault <= fault_r;
      rep_r.rng   <= rng_r;
      rep_r.mean  <= (state_r == R_CHK) ? '0 : q_r;
      rep_r.minv  <= (state_r == R_CHK) ? '0 : low_r;
      rep_r.maxv  <= (state_r == R_CHK) ? '0 : high_r;
      rep_r.std   <= (state_r == R_CHK) ? '0 : sq_root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      took_r  <= 1'b0;
      tally_r <= '0;
      over_r  <= '0;
      under_r <= '0;
      fault_r <= '0;
      rng_r   <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      low_r   <= '1;
      high_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            state_r <= head.match ? S_MUL2 : R_CHK;
          end
        end
        S_MUL2: state_r <= S_EST;
        S_EST:  state_r <= S_FIX;
        S_FIX:  state_r <= S_SQ;
        S_SQ: begin
          took_r <= take;
          if (take) begin
            tally_r <= tally_r + 1'b1;
            if (uv_r > cfg.over) over_r <= over_r + 1'b1;
            if (uv_r < cfg.under) under_r <= under_r + 1'b1;
            if (ent_r.fault_hit) fault_r <= fault_r + 1'b1;
            if (ent_r.range_hit) rng_r <= rng_r + 1'b1;
            sum_r <= sum_r + SUM_W'(uv_r);
            if (uv_r < low_r) low_r <= uv_r;
            if (uv_r > high_r) high_r <= uv_r;
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (took_r) begin
            sumsq_r <= sumsq_r + SQS_W'(sq_r);
          end
          state_r <= ent_r.last ? R_CHK : S_IDLE;
        end
        R_CHK: state_r <= (tally_r == '0) ? R_OUT : R_DIV1;
        R_DIV1: begin
          ret_r   <= R_M1;
          state_r <= R_WDIV;
        end
        R_WDIV: begin
          if (div_done) begin
            state_r <= ret_r;
          end
        end
        R_M1: state_r <= R_M2;
        R_M2: state_r <= R_M3;
        R_M3: state_r <= R_M4;
        R_M4: state_r <= R_DIV2;
        R_DIV2: begin
          ret_r   <= R_SUB1;
          state_r <= R_WDIV;
        end
        R_SUB1: state_r <= R_SUB2;
        R_SUB2: state_r <= R_DIV3;
        R_DIV3: begin
          ret_r   <= R_SQRT;
          state_r <= R_WDIV;
        end
        R_SQRT: state_r <= R_WSQ;
        R_WSQ: begin
          if (sq_done) begin
            state_r <= R_OUT;
          end
        end
        R_OUT: begin
          if (!rep_stall) begin
            tally_r <= '0;
            over_r  <= '0;
            under_r <= '0;
            fault_r <= '0;
            rng_r   <= '0;
            sum_r   <= '0;
            sumsq_r <= '0;
            low_r   <= '1;
            high_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
